// ===== src/dhfk_pkg.sv =====
// Shared types and constants for the DH chain forward kinematics block.
// No dependencies.
`timescale 1ns / 1ps
package dhfk_pkg;
    localparam int ROT_W = 18;
    localparam logic signed [ROT_W-1:0] ROT_MAX = 18'sd131071;
    localparam logic signed [ROT_W-1:0] ROT_MIN = -18'sd131072;
    localparam logic signed [ROT_W-1:0] ONE_Q16 = 18'sd65536;
    localparam int CORDIC_STEPS = 20;
    localparam logic signed [32:0] HALFPI_Q30 = 33'sd1686629713;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // Microcode ops issued by the controller to the datapath.
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_RED_TH, OP_CORDIC_TH, OP_FIN_TH, OP_RED_AL,
        OP_CORDIC_AL, OP_FIN_AL, OP_LOCAL, OP_MAC, OP_ROUND, OP_POS, OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
        logic [1:0] row;
        logic [1:0] col;
    } t_cmd;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage

// ===== src/dhfk_datapath.sv =====
// Datapath: shared CORDIC, one 18x34 multiplier with accumulator for the pose product, pose registers.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_datapath import dhfk_pkg::*; #(
    parameter int ANGLE_WIDTH  = 16,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  logic                           i_conv,
    input  logic                           i_first,
    input  logic signed [LENGTH_WIDTH-1:0] i_a,
    input  logic signed [ANGLE_WIDTH-1:0]  i_alpha,
    input  logic signed [LENGTH_WIDTH-1:0] i_d,
    input  logic signed [ANGLE_WIDTH-1:0]  i_toff,
    input  logic signed [ANGLE_WIDTH-1:0]  i_q,
    output logic signed [ROT_W-1:0]        o_rot [9],
    output logic signed [LENGTH_WIDTH-1:0] o_pos [3]
);
    localparam int FRAC = ANGLE_WIDTH - 3;
    localparam int AQ_W = ANGLE_WIDTH + 1 + 30 - FRAC;
    localparam int ACC_W = LENGTH_WIDTH + 40;
    localparam logic signed [ACC_W-1:0] P_MAX =
        {{(ACC_W-LENGTH_WIDTH+1){1'b0}}, {(LENGTH_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] P_MIN =
        {{(ACC_W-LENGTH_WIDTH+1){1'b1}}, {(LENGTH_WIDTH-1){1'b0}}};

    logic signed [ROT_W-1:0]        r_pr [9];
    logic signed [LENGTH_WIDTH-1:0] r_pp [3];
    logic signed [ROT_W-1:0]        r_rl [9];
    // Local translation needs one bit more: a*ct or d*sa can reach +2^(LENGTH_WIDTH-1).
    logic signed [LENGTH_WIDTH:0]   r_tl [3];
    logic signed [ROT_W-1:0]        r_st, r_ct, r_sa, r_ca;
    logic signed [LENGTH_WIDTH-1:0] r_a, r_d;
    logic signed [AQ_W-1:0]         r_th, r_al;
    logic signed [33:0]             r_x, r_y, r_r;
    logic [1:0]                     r_k;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [ROT_W-1:0]        r_rg [9];
    logic signed [LENGTH_WIDTH-1:0] r_pg [3];

    // Quadrant reduction: k = round(ang / halfpi). |ang| <= 8*2^30 so |k| <= 5.
    function automatic logic signed [3:0] quad(input logic signed [AQ_W-1:0] ang);
        logic [AQ_W-1:0] m;
        logic [3:0] k;
        m = ang[AQ_W-1] ? AQ_W'(-ang) : AQ_W'(ang);
        k = 4'd0;
        for (int j = 1; j <= 6; j++)
            if ((AQ_W+2)'(m) >= (AQ_W+2)'(HALFPI_Q30) * (AQ_W+2)'(j)
                    - (AQ_W+2)'(HALFPI_Q30 >>> 1)) k = 4'(j);
        return ang[AQ_W-1] ? -$signed(k) : $signed(k);
    endfunction

    function automatic logic signed [ROT_W-1:0] rnd14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd8192) >>> 14;
        if (t > 34'sd65536) t = 34'sd65536;
        if (t < -34'sd65536) t = -34'sd65536;
        return t[ROT_W-1:0];
    endfunction

    function automatic logic signed [ROT_W-1:0] rm(input logic signed [ROT_W-1:0] p,
                                                  input logic signed [ROT_W-1:0] q);
        logic signed [2*ROT_W-1:0] t;
        t = (p * q + 36'sd32768) >>> 16;
        return t[ROT_W-1:0];
    endfunction

    logic signed [AQ_W-1:0] w_ang;
    logic signed [3:0]      w_k;
    logic signed [ACC_W-1:0] w_prod;
    logic signed [ROT_W-1:0] w_m1;
    logic signed [LENGTH_WIDTH+1:0] w_m2;
    logic signed [ROT_W-1:0] w_c, w_s, w_fc, w_fs;
    logic [3:0] w_i;

    assign w_ang = (i_cmd.op == OP_RED_TH) ? r_th : r_al;
    assign w_k = quad(w_ang);
    assign w_c = rnd14(r_x);
    assign w_s = rnd14(r_y);
    always_comb begin
        unique case (r_k)
            2'd0: begin w_fc = w_c;  w_fs = w_s;  end
            2'd1: begin w_fc = -w_s; w_fs = w_c;  end
            2'd2: begin w_fc = -w_c; w_fs = -w_s; end
            default: begin w_fc = w_s; w_fs = -w_c; end
        endcase
    end

    // Multiplier operands: rotation entry times a rotation entry or a translation.
    always_comb begin
        w_i = 4'(i_cmd.row) * 4'd3 + 4'(i_cmd.step[1:0]);
        w_m1 = r_pr[w_i];
        if (i_cmd.op == OP_POS)
            w_m2 = (LENGTH_WIDTH+2)'(r_tl[i_cmd.step[1:0]]);
        else
            w_m2 = (LENGTH_WIDTH+2)'(r_rl[4'(i_cmd.step[1:0]) * 4'd3 + 4'(i_cmd.col)]);
        w_prod = ACC_W'(w_m1) * ACC_W'(w_m2);
    end

    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_pr;
    always_comb begin
        w_sum = (r_acc + ACC_W'(33'sd32768)) >>> 16;
        w_pr = w_sum + ACC_W'(r_pp[i_cmd.row]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 9; j++)
                r_pr[j] <= (j % 4 == 0) ? ONE_Q16 : '0;
            for (int j = 0; j < 3; j++) r_pp[j] <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_a <= i_a;
                    r_d <= i_d;
                    r_th <= AQ_W'((ANGLE_WIDTH+1)'(i_toff) + (ANGLE_WIDTH+1)'(i_q))
                            <<< (30 - FRAC);
                    r_al <= AQ_W'(i_alpha) <<< (30 - FRAC);
                    if (i_first) begin
                        for (int j = 0; j < 9; j++)
                            r_pr[j] <= (j % 4 == 0) ? ONE_Q16 : '0;
                        for (int j = 0; j < 3; j++) r_pp[j] <= '0;
                    end
                end
                OP_RED_TH, OP_RED_AL: begin
                    r_k <= w_k[1:0];
                    r_r <= 34'(w_ang - AQ_W'(w_k) * AQ_W'(HALFPI_Q30));
                    r_x <= 34'(CORDIC_GAIN);
                    r_y <= '0;
                end
                OP_CORDIC_TH, OP_CORDIC_AL: begin
                    if (!r_r[33]) begin
                        r_x <= r_x - (r_y >>> i_cmd.step);
                        r_y <= r_y + (r_x >>> i_cmd.step);
                        r_r <= r_r - 34'(atan_q30(i_cmd.step));
                    end else begin
                        r_x <= r_x + (r_y >>> i_cmd.step);
                        r_y <= r_y - (r_x >>> i_cmd.step);
                        r_r <= r_r + 34'(atan_q30(i_cmd.step));
                    end
                end
                OP_FIN_TH: begin r_ct <= w_fc; r_st <= w_fs; end
                OP_FIN_AL: begin r_ca <= w_fc; r_sa <= w_fs; end
                OP_LOCAL: begin
                    if (i_conv) begin
                        r_rl[0] <= r_ct; r_rl[1] <= -r_st; r_rl[2] <= '0;
                        r_rl[3] <= rm(r_st, r_ca); r_rl[4] <= rm(r_ct, r_ca);
                        r_rl[5] <= -r_sa;
                        r_rl[6] <= rm(r_st, r_sa); r_rl[7] <= rm(r_ct, r_sa);
                        r_rl[8] <= r_ca;
                        r_tl[0] <= (LENGTH_WIDTH+1)'(r_a);
                        r_tl[1] <= (LENGTH_WIDTH+1)'(-((ACC_W'(r_d) * ACC_W'(r_sa)
                                   + ACC_W'(33'sd32768)) >>> 16));
                        r_tl[2] <= (LENGTH_WIDTH+1)'((ACC_W'(r_d) * ACC_W'(r_ca)
                                   + ACC_W'(33'sd32768)) >>> 16);
                    end else begin
                        r_rl[0] <= r_ct; r_rl[1] <= -rm(r_st, r_ca);
                        r_rl[2] <= rm(r_st, r_sa);
                        r_rl[3] <= r_st; r_rl[4] <= rm(r_ct, r_ca);
                        r_rl[5] <= -rm(r_ct, r_sa);
                        r_rl[6] <= '0; r_rl[7] <= r_sa; r_rl[8] <= r_ca;
                        r_tl[0] <= (LENGTH_WIDTH+1)'((ACC_W'(r_a) * ACC_W'(r_ct)
                                   + ACC_W'(33'sd32768)) >>> 16);
                        r_tl[1] <= (LENGTH_WIDTH+1)'((ACC_W'(r_a) * ACC_W'(r_st)
                                   + ACC_W'(33'sd32768)) >>> 16);
                        r_tl[2] <= (LENGTH_WIDTH+1)'(r_d);
                    end
                end
                OP_MAC, OP_POS: r_acc <= (i_cmd.step == 5'd0) ? w_prod : r_acc + w_prod;
                OP_ROUND: begin
                    if (i_cmd.col == 2'd3) begin
                        if (w_pr > P_MAX)
                            r_pg[i_cmd.row] <= P_MAX[LENGTH_WIDTH-1:0];
                        else if (w_pr < P_MIN)
                            r_pg[i_cmd.row] <= P_MIN[LENGTH_WIDTH-1:0];
                        else r_pg[i_cmd.row] <= w_pr[LENGTH_WIDTH-1:0];
                    end else begin
                        if (w_sum > ACC_W'(ROT_MAX))
                            r_rg[4'(i_cmd.row)*4'd3 + 4'(i_cmd.col)] <= ROT_MAX;
                        else if (w_sum < ACC_W'(ROT_MIN))
                            r_rg[4'(i_cmd.row)*4'd3 + 4'(i_cmd.col)] <= ROT_MIN;
                        else
                            r_rg[4'(i_cmd.row)*4'd3 + 4'(i_cmd.col)] <= w_sum[ROT_W-1:0];
                    end
                end
                OP_COMMIT: begin
                    r_pr <= r_rg;
                    r_pp <= r_pg;
                end
                default: ;
            endcase
        end
    end

    assign o_rot = r_rg;
    assign o_pos = r_pg;
endmodule

// ===== src/dhfk_ctrl.sv =====
// Controller sequencing CORDIC, local transform and pose multiply per joint.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_ctrl import dhfk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_RTH, S_CTH, S_FTH, S_RAL, S_CAL, S_FAL, S_LOC,
        S_MAC, S_RND, S_COM, S_OUT
    } t_state;

    t_state     r_state;
    logic [4:0] r_step;
    logic [1:0] r_row, r_col;

    // Command issued in the current cycle, derived from state and counters.
    always_comb begin
        o_cmd = '{op: OP_NONE, step: r_step, row: r_row, col: r_col};
        unique case (r_state)
            S_IDLE: o_cmd.op = (i_in_valid && !o_out_valid) ? OP_LOAD : OP_NONE;
            S_RTH: o_cmd.op = OP_RED_TH;
            S_CTH: o_cmd.op = OP_CORDIC_TH;
            S_FTH: o_cmd.op = OP_FIN_TH;
            S_RAL: o_cmd.op = OP_RED_AL;
            S_CAL: o_cmd.op = OP_CORDIC_AL;
            S_FAL: o_cmd.op = OP_FIN_AL;
            S_LOC: o_cmd.op = OP_LOCAL;
            S_MAC: o_cmd.op = (r_col == 2'd3) ? OP_POS : OP_MAC;
            S_RND: o_cmd.op = OP_ROUND;
            S_COM: o_cmd.op = OP_COMMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE) && !o_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0; r_row <= '0; r_col <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && !o_out_valid) r_state <= S_RTH;
                S_RTH: begin r_state <= S_CTH; r_step <= '0; end
                S_CTH: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(CORDIC_STEPS - 1)) r_state <= S_FTH;
                end
                S_FTH: r_state <= S_RAL;
                S_RAL: begin r_state <= S_CAL; r_step <= '0; end
                S_CAL: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(CORDIC_STEPS - 1)) r_state <= S_FAL;
                end
                S_FAL: r_state <= S_LOC;
                S_LOC: begin
                    r_state <= S_MAC; r_step <= '0; r_row <= '0; r_col <= '0;
                end
                S_MAC: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd2) r_state <= S_RND;
                end
                S_RND: begin
                    r_step <= '0;
                    r_state <= S_MAC;
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd2) r_state <= S_COM;
                    end
                end
                S_COM: r_state <= S_OUT;
                S_OUT: begin
                    o_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT) else $error("stray result");
endmodule

// ===== src/dh_chain_forward_kinematics.sv =====
// Top level of the DH chain forward kinematics block.
// Depends on dhfk_pkg, dhfk_ctrl, dhfk_datapath.
//
//  channel  | dir | contents
//  s_axis   | in  | one joint: tuser first_joint, tdata a, alpha, d, theta_off, q
//  m_axis   | out | one global pose: 9 rotation entries then x, y, z
//  cfg      | in  | dh_convention (bit 0)
//
// After a joint's transfer, each of the two angles takes its own run (reduce,
// 20 CORDIC steps, finish) on one shared rotator; then come the local
// transform, the multiply/accumulate pass (12 entries of 3 products, each
// with a rounding step), a commit state and an output state. Reset is
// synchronous and restores identity pose and standard convention. A finished
// pose waits in its output register; the next joint is taken once the pose is
// transferred, so the block takes no new joint while one is in flight.
`timescale 1ns / 1ps
module dh_chain_forward_kinematics import dhfk_pkg::*; #(
    parameter int ANGLE_WIDTH  = 16,
    parameter int LENGTH_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // link_length, link_twist, link_offset, joint_offset, joint_angle (low first)
    input  logic [((2*LENGTH_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // first_joint
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // rot_xx..rot_zz (18 bits each), pos_x, pos_y, pos_z (low first)
    output logic [((9*ROT_W+3*LENGTH_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    localparam int OFF_AL = LENGTH_WIDTH;
    localparam int OFF_D  = OFF_AL + ANGLE_WIDTH;
    localparam int OFF_TO = OFF_D + LENGTH_WIDTH;
    localparam int OFF_Q  = OFF_TO + ANGLE_WIDTH;

    logic r_conv;
    t_cmd w_cmd;
    logic signed [ROT_W-1:0]        w_rot [9];
    logic signed [LENGTH_WIDTH-1:0] w_pos [3];

    // Hold the convention bit; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_conv <= 1'b0;
        else if (i_cfg_we) r_conv <= i_cfg_wdata;
    end

    dhfk_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd)
    );

    dhfk_datapath #(.ANGLE_WIDTH(ANGLE_WIDTH), .LENGTH_WIDTH(LENGTH_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_conv(r_conv), .i_first(s_axis_tuser),
        .i_a(s_axis_tdata[LENGTH_WIDTH-1:0]),
        .i_alpha(s_axis_tdata[OFF_AL +: ANGLE_WIDTH]),
        .i_d(s_axis_tdata[OFF_D +: LENGTH_WIDTH]),
        .i_toff(s_axis_tdata[OFF_TO +: ANGLE_WIDTH]),
        .i_q(s_axis_tdata[OFF_Q +: ANGLE_WIDTH]),
        .o_rot(w_rot), .o_pos(w_pos)
    );

    // Pack the pose registers, rotation row major first.
    always_comb begin
        m_axis_tdata = '0;
        for (int j = 0; j < 9; j++) m_axis_tdata[j*ROT_W +: ROT_W] = w_rot[j];
        for (int j = 0; j < 3; j++)
            m_axis_tdata[9*ROT_W + j*LENGTH_WIDTH +: LENGTH_WIDTH] = w_pos[j];
    end
endmodule

// ===== dv/dh_chain_forward_kinematics_tb.sv =====
// Testbench for dh_chain_forward_kinematics: drives joints over the input stream,
// predicts each global pose with an independent fixed-point model and checks it.
// Depends on dhfk_pkg and the block's RTL.
`timescale 1ns / 1ps
module dh_chain_forward_kinematics_tb import dhfk_pkg::*; ();

    localparam int AW = 16;
    localparam int LW = 32;
    localparam int IN_W = ((2*LW+3*AW+7)/8)*8;
    localparam int OUT_W = ((9*ROT_W+3*LW+7)/8)*8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int STALL_CYCLES = 600;
    localparam longint Q30_HALFPI = 64'sd1686629713;

    typedef struct packed {
        logic              first;
        logic signed [LW-1:0] a;
        logic signed [AW-1:0] alpha;
        logic signed [LW-1:0] d;
        logic signed [AW-1:0] toff;
        logic signed [AW-1:0] q;
    } t_joint;

    // Same layout as the output tdata: rotation in the low bits, index 0 = xx.
    typedef struct packed {
        logic signed [2:0][LW-1:0]    pos;
        logic signed [8:0][ROT_W-1:0] rot;
    } t_pose;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic i_cfg_wdata = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;

    // Predictor state: running pose and convention.
    longint pose_r[3][3];
    longint pose_p[3];
    bit     conv_modified;
    t_pose  pending_poses[$];
    int     error_count = 0;
    int     idle_cycles = 0;
    int     hold_requests = 0;
    int     hold_seen = 0;
    int     stall_len = 0;
    int     rx_wait = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    dh_chain_forward_kinematics #(.ANGLE_WIDTH(AW), .LENGTH_WIDTH(LW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic longint floor_shr(longint x, int k);
        return x >>> k;   // arithmetic shift is floor division
    endfunction

    function automatic longint round16(longint p);
        return floor_shr(p + 32768, 16);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint scale_len(longint v, longint c);
        longint vh, vl;
        vh = floor_shr(v, 16);
        vl = v - vh * 65536;
        return vh * c + floor_shr(vl * c + 32768, 16);
    endfunction

    // CORDIC sine/cosine of a Q30 angle, results in Q16.
    task automatic cordic_sincos(input longint ang, output longint sn, output longint cs);
        longint k, r, x, y, dx, dy, c, s;
        x = 64'sd652032874;
        y = 0;
        if (ang >= 0) k = (ang + Q30_HALFPI / 2) / Q30_HALFPI;
        else k = -((-ang + Q30_HALFPI / 2) / Q30_HALFPI);
        r = ang - k * Q30_HALFPI;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (r >= 0) begin
                x -= dx; y += dy; r -= longint'(atan_q30(i[4:0]));
            end else begin
                x += dx; y -= dy; r += longint'(atan_q30(i[4:0]));
            end
        end
        c = clip(floor_shr(x + 8192, 14), -65536, 65536);
        s = clip(floor_shr(y + 8192, 14), -65536, 65536);
        case (k & 3)
            0: begin cs = c;  sn = s;  end
            1: begin cs = -s; sn = c;  end
            2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endtask

    // Advance the running pose by one joint and return the global pose.
    task automatic chain_joint(input t_joint j, output t_pose pz);
        longint st, ct, sa, ca, acc, hi, lo, th, tlo, pmax, pmin;
        longint rl[3][3], tl[3], rg[3][3], pg[3];
        pmax = (64'sd1 <<< (LW - 1)) - 1;
        pmin = -pmax - 1;
        if (j.first) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) pose_r[r][c] = (r == c) ? 65536 : 0;
                pose_p[r] = 0;
            end
        end
        cordic_sincos((longint'(j.toff) + longint'(j.q)) * (64'sd1 <<< (30 - (AW - 3))), st, ct);
        cordic_sincos(longint'(j.alpha) * (64'sd1 <<< (30 - (AW - 3))), sa, ca);
        if (conv_modified) begin
            rl[0][0] = ct; rl[0][1] = -st; rl[0][2] = 0;
            rl[1][0] = round16(st * ca); rl[1][1] = round16(ct * ca); rl[1][2] = -sa;
            rl[2][0] = round16(st * sa); rl[2][1] = round16(ct * sa); rl[2][2] = ca;
            tl[0] = j.a;
            tl[1] = -scale_len(j.d, sa);
            tl[2] = scale_len(j.d, ca);
        end else begin
            rl[0][0] = ct; rl[0][1] = -round16(st * ca); rl[0][2] = round16(st * sa);
            rl[1][0] = st; rl[1][1] = round16(ct * ca); rl[1][2] = -round16(ct * sa);
            rl[2][0] = 0;  rl[2][1] = sa; rl[2][2] = ca;
            tl[0] = scale_len(j.a, ct);
            tl[1] = scale_len(j.a, st);
            tl[2] = j.d;
        end
        for (int r = 0; r < 3; r++) begin
            hi = 0; lo = 0;
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int m = 0; m < 3; m++) acc += pose_r[r][m] * rl[m][c];
                rg[r][c] = clip(round16(acc), -131072, 131071);
            end
            for (int m = 0; m < 3; m++) begin
                th = floor_shr(tl[m], 16);
                tlo = tl[m] - th * 65536;
                hi += pose_r[r][m] * th;
                lo += pose_r[r][m] * tlo;
            end
            pg[r] = clip(pose_p[r] + hi + floor_shr(lo + 32768, 16), pmin, pmax);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                pose_r[r][c] = rg[r][c];
                pz.rot[r*3+c] = rg[r][c][ROT_W-1:0];
            end
            pose_p[r] = pg[r];
            pz.pos[r] = pg[r][LW-1:0];
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Send one joint; the prediction is queued at the transfer. Valid stays
    // high after the transfer when the next joint follows without a gap.
    task automatic send_joint(input t_joint j);
        t_pose pz;
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= j.first;
        s_axis_tdata  <= {j.q, j.toff, j.d, j.alpha, j.a};
        do @(posedge i_clk); while (!s_axis_tready);
        chain_joint(j, pz);
        pending_poses = {pending_poses, pz};
    endtask

    // Wait for all poses, then let the block settle before touching config.
    task automatic drain_and_set(input bit modified);
        s_axis_tvalid <= 0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= modified;
        @(posedge i_clk);
        i_cfg_we <= 0;
        conv_modified = modified;
    endtask

    function automatic t_joint rand_joint(bit first);
        t_joint j;
        j.first = first;
        // Mostly moderate lengths, sometimes the full range to force saturation.
        j.a = ($urandom_range(0, 7) == 0) ? $urandom : $signed($urandom_range(0, 2**22)) - 2**21;
        j.d = ($urandom_range(0, 7) == 0) ? $urandom : $signed($urandom_range(0, 2**22)) - 2**21;
        j.alpha = AW'($urandom);
        j.toff = AW'($urandom);
        j.q = AW'($urandom);
        return j;
    endfunction

    // Extremes of every field, chain with no first joint from the current pose (reset pose on the first call).
    task automatic test_directed();
        t_joint j;
        j = '{0, 32'sd65536, 16'sd0, 16'sd0 + 32'sd0, 0, 0};
        send_joint(j);                         // from the current pose
        j = '{1, 32'h7fffffff, 16'h7fff, 32'h7fffffff, 16'h7fff, 16'h7fff};
        send_joint(j);
        j = '{0, 32'h80000000, 16'h8000, 32'h80000000, 16'h8000, 16'h8000};
        send_joint(j);                         // position overflow
        j = '{0, 32'h7fffffff, 16'h4000, 32'h7fffffff, 16'h3000, 16'h1000};
        send_joint(j);
        j = '{1, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 16'hffff};
        send_joint(j);
        for (int i = 0; i < 6; i++) send_joint(rand_joint(i == 0));
    endtask

    task automatic test_random_chains(input int n);
        int i;
        i = 0;
        while (i < n) begin
            send_joint(rand_joint(i % ($urandom_range(2, 8)) == 0 || $urandom_range(0, 15) == 0));
            i++;
        end
    endtask

    // Hold the receiver off long enough that the block fills and stalls its input.
    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 6; i++) send_joint(rand_joint(i == 0));
    endtask

    // Result side: per-pose random wait, long hold when requested, per-field compare.
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            rx_wait <= 0;
            stall_len <= 0;
            hold_seen <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_poses.size() == 0) begin
                    report_mismatch("unexpected pose", 0, 0);
                end else begin
                    t_pose want, got;
                    want = pending_poses.pop_front();
                    got = m_axis_tdata[9*ROT_W+3*LW-1:0];
                    for (int k = 0; k < 9; k++)
                        if (got.rot[k] !== want.rot[k])
                            report_mismatch($sformatf("rot[%0d]", k), got.rot[k], want.rot[k]);
                    for (int k = 0; k < 3; k++)
                        if (got.pos[k] !== want.pos[k])
                            report_mismatch($sformatf("pos[%0d]", k), got.pos[k], want.pos[k]);
                end
            end
            if (hold_requests != hold_seen) begin
                hold_seen <= hold_requests;
                stall_len <= STALL_CYCLES;
                m_axis_tready <= 0;
            end else if (stall_len != 0) begin
                stall_len <= stall_len - 1;
                m_axis_tready <= 0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                gap = $urandom_range(0, 5);
                rx_wait <= gap;
                m_axis_tready <= (gap == 0);
            end else if (!m_axis_tready) begin
                if (rx_wait == 0) m_axis_tready <= 1;
                else rx_wait <= rx_wait - 1;
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) pose_r[r][c] = (r == c) ? 65536 : 0;
            pose_p[r] = 0;
        end
        conv_modified = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random_chains(140);
        drain_and_set(1);
        test_directed();
        test_random_chains(140);
        test_backpressure();
        drain_and_set(0);
        test_random_chains(70);
        drain_and_set(1);
        test_random_chains(60);
        s_axis_tvalid <= 0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (error_count == 0 && pending_poses.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== dh_chain_forward_kinematics.f =====
src/dhfk_pkg.sv
src/dhfk_datapath.sv
src/dhfk_ctrl.sv
src/dh_chain_forward_kinematics.sv
dv/dh_chain_forward_kinematics_tb.sv
